/* rtl/tpe_pkg.sv */
// Shared types, constants and byte helpers for the token proposal extractor.
package tpe_pkg;

   localparam int LIMIT_W    = 4;
   localparam int BYTE_W     = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_W     = BYTE_W * WORD_BYTES;
   localparam int TIME_W     = 64;
   localparam int SCORE_W    = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   localparam logic KIND_TOKEN = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_NONE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND,
      ST_FINISH
   } back_state_type;

   // control part of one queued command
   typedef struct packed {
      logic emit;
      logic bank;
      logic done;
      logic status;
   } cmd_ctl_type;

   // byte write into the token store
   typedef struct packed {
      logic              en;
      logic              bank;
      logic [2:0]        lane;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   // back end hands a token bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   function automatic logic is_token_char(input logic [BYTE_W-1:0] c);
      logic digit;
      logic upper;
      logic lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      upper = (c >= 8'h41) && (c <= 8'h5a);
      lower = (c >= 8'h61) && (c <= 8'h7a);
      return digit || upper || lower || (c == 8'h5f) || (c == 8'h2d);
   endfunction

   function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if ((c >= 8'h41) && (c <= 8'h5a)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

/* rtl/token_proposal_extractor.sv */
// Top level of the token proposal extractor: front end, command queue, back end.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  query_byte, query_first, query_last, base_time
//  rsp_     out        rsp_valid/rsp_stall  result_kind ... run_last (one result per transfer)
//  csr_     in         csr_wr_en            csr_wr_data = prop_cap
//
// A byte transfers when the command queue has room and its token bank is free.
// A proposal holds the back end for ST_IDLE, then a store read and an output load per word;
// a done result takes ST_IDLE and ST_FINISH, or only ST_FINISH after a proposal's last word.
// Two token banks let the next run fill while the previous one drains.
// Reset is synchronous; the token store is not cleared.
// Output stall holds the result register and backs up through the queue to req_stall.
module token_proposal_extractor
   import tpe_pkg::*;
   #(parameter int TOKEN_BYTES   = 96,
     parameter int MAX_PROPOSALS = 8,
     parameter int MIN_TOKEN     = 3,
     localparam int LEN_W = $clog2(TOKEN_BYTES),
     localparam int CNT_W = $clog2(MAX_PROPOSALS + 1))
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_query_byte,
   input  logic                req_query_first,
   input  logic                req_query_last,
   input  logic [TIME_W-1:0]   req_base_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [WORD_W-1:0]   rsp_token_word,
   output logic                rsp_word_last,
   output logic [LEN_W-1:0]    rsp_token_length,
   output logic [SCORE_W-1:0]  rsp_proposal_score,
   output logic [TIME_W-1:0]   rsp_proposal_time,
   output logic [CNT_W-1:0]    rsp_proposal_count,
   output logic                rsp_done_status,
   output logic                rsp_run_last,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
   );

   localparam int ROWS   = (TOKEN_BYTES + WORD_BYTES - 2) / WORD_BYTES;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CTL_W  = $bits(cmd_ctl_type);
   localparam int CMD_W  = CTL_W + LEN_W + CNT_W + TIME_W;

   store_wr_type       wr;
   logic [ROW_W-1:0]   wr_row;
   logic               push;
   cmd_ctl_type        push_ctl;
   logic [LEN_W-1:0]   push_len;
   logic [CNT_W-1:0]   push_count;
   logic [TIME_W-1:0]  push_time;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic [CMD_W-1:0]   q_head;
   cmd_ctl_type        q_ctl;
   logic [LEN_W-1:0]   q_len;
   logic [CNT_W-1:0]   q_count;
   logic [TIME_W-1:0]  q_time;
   release_type        rel;

   assign {q_ctl, q_len, q_count, q_time} = q_head;

   tpe_front #(
      .TOKEN_BYTES   (TOKEN_BYTES),
      .MAX_PROPOSALS (MAX_PROPOSALS),
      .MIN_TOKEN     (MIN_TOKEN),
      .LEN_W         (LEN_W),
      .CNT_W         (CNT_W),
      .ROW_W         (ROW_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_query_byte  (req_query_byte),
      .req_query_first (req_query_first),
      .req_query_last  (req_query_last),
      .req_base_time   (req_base_time),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .wr              (wr),
      .wr_row          (wr_row),
      .push            (push),
      .push_ctl        (push_ctl),
      .push_len        (push_len),
      .push_count      (push_count),
      .push_time       (push_time),
      .q_full          (q_full),
      .rel             (rel)
   );

   tpe_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctl, push_len, push_count, push_time}),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop)
   );

   tpe_back #(
      .LEN_W (LEN_W),
      .CNT_W (CNT_W),
      .ROW_W (ROW_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .wr                 (wr),
      .wr_row             (wr_row),
      .q_valid            (q_valid),
      .q_ctl              (q_ctl),
      .q_len              (q_len),
      .q_count            (q_count),
      .q_time             (q_time),
      .q_pop              (q_pop),
      .rel                (rel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_token_word     (rsp_token_word),
      .rsp_word_last      (rsp_word_last),
      .rsp_token_length   (rsp_token_length),
      .rsp_proposal_score (rsp_proposal_score),
      .rsp_proposal_time  (rsp_proposal_time),
      .rsp_proposal_count (rsp_proposal_count),
      .rsp_done_status    (rsp_done_status),
      .rsp_run_last       (rsp_run_last)
   );

endmodule

/* rtl/tpe_queue.sv */
// Two-entry command queue between the front end and the back end.
module tpe_queue
   #(parameter int WIDTH = 8)
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   input  logic             pop
   );

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       cnt_ff;
   logic [1:0]       cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/tpe_front.sv */
// Front end: takes query bytes, collects runs into the token store, queues commands.
module tpe_front
   import tpe_pkg::*;
   #(parameter int TOKEN_BYTES   = 96,
     parameter int MAX_PROPOSALS = 8,
     parameter int MIN_TOKEN     = 3,
     parameter int LEN_W         = 7,
     parameter int CNT_W         = 4,
     parameter int ROW_W         = 4)
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_query_byte,
   input  logic                req_query_first,
   input  logic                req_query_last,
   input  logic [TIME_W-1:0]   req_base_time,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   output store_wr_type        wr,
   output logic [ROW_W-1:0]    wr_row,
   output logic                push,
   output cmd_ctl_type         push_ctl,
   output logic [LEN_W-1:0]    push_len,
   output logic [CNT_W-1:0]    push_count,
   output logic [TIME_W-1:0]   push_time,
   input  logic                q_full,
   input  release_type         rel
   );

   logic [LIMIT_W-1:0] limit_ff;
   logic [LEN_W-1:0]   fill_ff;
   logic [LEN_W-1:0]   fill_in;
   logic [CNT_W-1:0]   emitted_ff;
   logic [CNT_W-1:0]   emitted_in;
   logic [TIME_W-1:0]  held_ff;
   logic [TIME_W-1:0]  held_in;
   logic               stopped_ff;
   logic               stopped_in;
   logic               bank_ff;
   logic               bank_in;
   logic [1:0]         busy_ff;
   logic [1:0]         busy_in;

   logic               accept;
   logic [LEN_W-1:0]   fill_e;
   logic [CNT_W-1:0]   emitted_e;
   logic [TIME_W-1:0]  held_e;
   logic               stopped_e;
   logic [LIMIT_W:0]   lim;
   logic               limit_ok;
   logic               is_tok;
   logic               app;
   logic               end_q;
   logic               flush;
   logic               emit;
   logic [LEN_W-1:0]   new_fill;
   logic [CNT_W-1:0]   emitted_new;

   assign req_stall = q_full || busy_ff[bank_ff];
   assign accept    = req_valid && !req_stall;

   always_comb begin
      fill_e    = req_query_first ? '0 : fill_ff;
      emitted_e = req_query_first ? '0 : emitted_ff;
      held_e    = req_query_first ? req_base_time : held_ff;
      stopped_e = req_query_first ? 1'b0 : stopped_ff;

      if (limit_ff == '0) begin
         lim = (LIMIT_W+1)'(1);
      end else if ({1'b0, limit_ff} > (LIMIT_W+1)'(MAX_PROPOSALS)) begin
         lim = (LIMIT_W+1)'(MAX_PROPOSALS);
      end else begin
         lim = {1'b0, limit_ff};
      end
      limit_ok = int'(emitted_e) < int'(lim);

      is_tok      = is_token_char(req_query_byte);
      app         = !stopped_e && is_tok && limit_ok && (fill_e < LEN_W'(TOKEN_BYTES - 1));
      new_fill    = fill_e + LEN_W'(app);
      end_q       = !stopped_e && ((req_query_byte == '0) || req_query_last);
      flush       = end_q || (!stopped_e && (req_query_byte != '0) && !is_tok);
      emit        = flush && limit_ok && (int'(new_fill) >= MIN_TOKEN);
      emitted_new = emitted_e + CNT_W'(emit);

      fill_in    = flush ? '0 : new_fill;
      emitted_in = emitted_new;
      held_in    = held_e;
      stopped_in = stopped_e || end_q;
      bank_in    = bank_ff ^ emit;

      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept && emit) begin
         busy_in[bank_ff] = 1'b1;
      end

      wr.en   = accept && app;
      wr.bank = bank_ff;
      wr.lane = fill_e[2:0];
      wr.data = to_lower(req_query_byte);
      wr_row  = ROW_W'(fill_e >> 3);

      push            = accept && (emit || end_q);
      push_ctl.emit   = emit;
      push_ctl.bank   = bank_ff;
      push_ctl.done   = end_q;
      push_ctl.status = (emitted_new == '0) ? STATUS_NONE : STATUS_FOUND;
      push_len        = new_fill;
      push_count      = emitted_new;
      push_time       = held_e + TIME_W'(emitted_e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         emitted_ff <= '0;
         held_ff    <= '0;
         stopped_ff <= 1'b0;
         bank_ff    <= 1'b0;
         busy_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            fill_ff    <= fill_in;
            emitted_ff <= emitted_in;
            held_ff    <= held_in;
            stopped_ff <= stopped_in;
            bank_ff    <= bank_in;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(emitted_ff) <= MAX_PROPOSALS)
      else $error("proposal count above maximum");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) < TOKEN_BYTES)
      else $error("token fill past store");

endmodule

/* rtl/tpe_back.sv */
// Back end: token store, score table and result sequencing onto the output register.
module tpe_back
   import tpe_pkg::*;
   #(parameter int LEN_W = 7,
     parameter int CNT_W = 4,
     parameter int ROW_W = 4)
   (
   input  logic                clock,
   input  logic                reset,
   input  store_wr_type        wr,
   input  logic [ROW_W-1:0]    wr_row,
   input  logic                q_valid,
   input  cmd_ctl_type         q_ctl,
   input  logic [LEN_W-1:0]    q_len,
   input  logic [CNT_W-1:0]    q_count,
   input  logic [TIME_W-1:0]   q_time,
   output logic                q_pop,
   output release_type         rel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [WORD_W-1:0]   rsp_token_word,
   output logic                rsp_word_last,
   output logic [LEN_W-1:0]    rsp_token_length,
   output logic [SCORE_W-1:0]  rsp_proposal_score,
   output logic [TIME_W-1:0]   rsp_proposal_time,
   output logic [CNT_W-1:0]    rsp_proposal_count,
   output logic                rsp_done_status,
   output logic                rsp_run_last
   );

   localparam int MEM_DEPTH = 2 << ROW_W;
   localparam int SCORE_N   = 1 << LEN_W;

   logic [WORD_W-1:0]  mem [MEM_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic [SCORE_W-1:0] score_tab [SCORE_N];

   back_state_type     state_ff;
   back_state_type     state_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [ROW_W-1:0]   last_row;
   logic               is_last;
   logic               out_free;
   logic               load_word;
   logic               load_done;
   logic [WORD_W-1:0]  masked;

   logic               valid_ff;
   logic               kind_ff;
   logic [WORD_W-1:0]  word_ff;
   logic               wlast_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               status_ff;
   logic               run_last_ff;

   // score = round((4L+14)*65536 / (5(L+8))), halves up
   for (genvar g = 0; g < SCORE_N; g++) begin : g_score
      localparam logic [63:0] NUM = 64'(4 * g + 14) * 64'd65536;
      localparam logic [63:0] DEN = 64'(5 * (g + 8));
      localparam logic [63:0] QUO = (NUM * 64'd2 + DEN) / (DEN * 64'd2);
      assign score_tab[g] = QUO[SCORE_W-1:0];
   end

   assign out_free = !valid_ff || !rsp_stall;
   assign last_row = ROW_W'((q_len - LEN_W'(1)) >> 3);
   assign is_last  = (row_ff == last_row);

   always_comb begin
      for (int b = 0; b < WORD_BYTES; b++) begin
         if (int'({row_ff, 3'(b)}) < int'(q_len)) begin
            masked[b*BYTE_W +: BYTE_W] = rd_data_ff[b*BYTE_W +: BYTE_W];
         end else begin
            masked[b*BYTE_W +: BYTE_W] = '0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      q_pop     = 1'b0;
      rel       = '0;
      load_word = 1'b0;
      load_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               row_in   = '0;
               state_in = q_ctl.emit ? ST_FETCH : ST_FINISH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               load_word = 1'b1;
               if (is_last) begin
                  rel.valid = 1'b1;
                  rel.bank  = q_ctl.bank;
                  if (q_ctl.done) begin
                     state_in = ST_FINISH;
                  end else begin
                     q_pop    = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_done = 1'b1;
               q_pop     = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr_row}][{wr.lane, 3'b000} +: BYTE_W] <= wr.data;
      end
      rd_data_ff <= mem[{q_ctl.bank, row_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_word || load_done) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_word) begin
         kind_ff     <= KIND_TOKEN;
         word_ff     <= masked;
         wlast_ff    <= is_last;
         len_ff      <= q_len;
         score_ff    <= score_tab[q_len];
         time_ff     <= q_time;
         count_ff    <= '0;
         status_ff   <= 1'b0;
         run_last_ff <= is_last && !q_ctl.done;
      end else if (load_done) begin
         kind_ff     <= KIND_DONE;
         word_ff     <= '0;
         wlast_ff    <= 1'b0;
         len_ff      <= '0;
         score_ff    <= '0;
         time_ff     <= '0;
         count_ff    <= q_count;
         status_ff   <= q_ctl.status;
         run_last_ff <= 1'b1;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_token_word     = word_ff;
   assign rsp_word_last      = wlast_ff;
   assign rsp_token_length   = len_ff;
   assign rsp_proposal_score = score_ff;
   assign rsp_proposal_time  = time_ff;
   assign rsp_proposal_count = count_ff;
   assign rsp_done_status    = status_ff;
   assign rsp_run_last       = run_last_ff;

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_row_in_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (row_ff <= last_row))
      else $error("word fetch past end of token");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == KIND_DONE)) |-> run_last_ff)
      else $error("done result not marked last");

endmodule

/* verif/tb.sv */
// Self-checking testbench for token_proposal_extractor: directed table, then random queries.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpe_pkg::*;

   localparam int HALF_NS       = 10;
   localparam int KEEP_BYTES    = 96;
   localparam int MAX_PROPOSALS = 8;
   localparam int MIN_RUN       = 3;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 10;
   localparam int RUN_LIMIT_NS  = 12_000_000;
   localparam logic [3:0] PHASE_LIMIT [PHASES] = '{4'd15, 4'd3, 4'd1, 4'd8, 4'd0, 4'd6};

   typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_type;

   // for a ROW_LIMIT row, cnt holds the value written to the proposal cap
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   b;
      logic         first;
      logic         last;
      logic [63:0]  t;
      logic         typed;
      logic [3:0]   cnt;
      logic         status;
   } dir_row_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] word;
      logic        wlast;
      logic [6:0]  len;
      logic [15:0] score;
      logic [63:0] ptime;
      logic [3:0]  count;
      logic        status;
      logic        run_last;
   } tpe_result_type;

   localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   dir_row_type dir_rows [28] = '{
      '{ROW_BYTE,  "A",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "b",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "Z",   1'b0, 1'b1, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "x",   1'b0, 1'b0, 64'd9, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  8'h00, 1'b1, 1'b0, T_MAX, 1'b1, 4'd0, STATUS_NONE},
      '{ROW_BYTE,  "-",   1'b1, 1'b0, T_MAX, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "_",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "9",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  8'h80, 1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "z",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "a",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "0",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "a",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  8'h00, 1'b0, 1'b0, 64'd0, 1'b1, 4'd2, STATUS_FOUND},
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0, 4'd1, STATUS_FOUND},
      '{ROW_BYTE,  "k",   1'b1, 1'b0, 64'd5, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "k",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "k",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  ",",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "m",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "m",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "m",   1'b0, 1'b1, 64'd0, 1'b1, 4'd1, STATUS_FOUND},
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "Q",   1'b1, 1'b0, 64'd7, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "q",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "q",   1'b0, 1'b0, 64'd0, 1'b0, 4'd0, STATUS_FOUND},
      '{ROW_BYTE,  "w",   1'b0, 1'b1, 64'd0, 1'b0, 4'd0, STATUS_FOUND}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_query_byte = 8'd0;
   logic        req_query_first = 1'b0;
   logic        req_query_last = 1'b0;
   logic [63:0] req_base_time = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [63:0] rsp_token_word;
   logic        rsp_word_last;
   logic [6:0]  rsp_token_length;
   logic [15:0] rsp_proposal_score;
   logic [63:0] rsp_proposal_time;
   logic [3:0]  rsp_proposal_count;
   logic        rsp_done_status;
   logic        rsp_run_last;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = 4'd0;

   // token extraction state mirrored from the block
   logic [7:0]  run_bytes [KEEP_BYTES];
   int          run_fill = 0;
   int          sent_cnt = 0;
   logic [63:0] held_time = 64'd0;
   logic        stopped = 1'b0;
   logic [3:0]  limit_reg = LIMIT_RESET;

   tpe_result_type step_out [$];
   tpe_result_type want_q [$];

   int send_idle_pct = 32;
   int recv_idle_pct = 84;
   int mismatch_cnt = 0;
   int n_items = 0;
   int n_queries = 0;
   int n_words = 0;
   int n_done = 0;
   int phase_items = 0;

   token_proposal_extractor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_query_byte     (req_query_byte),
      .req_query_first    (req_query_first),
      .req_query_last     (req_query_last),
      .req_base_time      (req_base_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_token_word     (rsp_token_word),
      .rsp_word_last      (rsp_word_last),
      .rsp_token_length   (rsp_token_length),
      .rsp_proposal_score (rsp_proposal_score),
      .rsp_proposal_time  (rsp_proposal_time),
      .rsp_proposal_count (rsp_proposal_count),
      .rsp_done_status    (rsp_done_status),
      .rsp_run_last       (rsp_run_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #(HALF_NS) clock = ~clock;

   function automatic logic is_run_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "_" || c == "-";
   endfunction

   function automatic logic [7:0] pick_delim();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (is_run_char(c));
      return c;
   endfunction

   function automatic int limit_now();
      if (limit_reg == 4'd0) return 1;
      if (limit_reg > MAX_PROPOSALS) return MAX_PROPOSALS;
      return limit_reg;
   endfunction

   function automatic void flush_run();
      int len;
      int pos;
      int j;
      longint unsigned num;
      longint unsigned den;
      tpe_result_type r;
      len = run_fill;
      run_fill = 0;
      if (len >= MIN_RUN && sent_cnt < limit_now()) begin
         num = longint'(4 * len + 14) * 65536;
         den = longint'(5 * (len + 8));
         for (pos = 0; pos < len; pos += 8) begin
            r = '0;
            r.kind  = KIND_TOKEN;
            r.len   = 7'(len);
            r.score = 16'((num * 2 + den) / (den * 2));
            r.ptime = held_time + 64'(sent_cnt);
            for (j = 0; j < 8 && pos + j < len; j++) begin
               r.word[8*j +: 8] = run_bytes[pos + j];
            end
            r.wlast = (pos + 8 >= len);
            step_out.push_back(r);
         end
         sent_cnt++;
      end
   endfunction

   // results one accepted query byte causes, left in step_out
   function automatic void predict_byte(input logic [7:0] c, input logic first,
                                        input logic last, input logic [63:0] t);
      tpe_result_type r;
      step_out.delete();
      if (first) begin
         run_fill  = 0;
         sent_cnt  = 0;
         stopped   = 1'b0;
         held_time = t;
      end
      if (stopped) return;
      if (c != 8'd0 && is_run_char(c)) begin
         if (sent_cnt < limit_now() && run_fill + 1 < KEEP_BYTES) begin
            run_bytes[run_fill] = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
            run_fill++;
         end
      end else if (c != 8'd0) begin
         flush_run();
      end
      if (c == 8'd0 || last) begin
         flush_run();
         r = '0;
         r.kind   = KIND_DONE;
         r.count  = 4'(sent_cnt);
         r.status = (sent_cnt > 0) ? STATUS_FOUND : STATUS_NONE;
         step_out.push_back(r);
         stopped = 1'b1;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
   endfunction

   task automatic send_item(input logic [7:0] c, input logic first, input logic last,
                            input logic [63:0] t, input logic typed = 1'b0,
                            input logic [3:0] cnt = 4'd0, input logic status = 1'b0);
      tpe_result_type r;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_query_byte  <= c;
      req_query_first <= first;
      req_query_last  <= last;
      req_base_time   <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(c, first, last, t);
      if (typed) begin
         r = '{KIND_DONE, 64'd0, 1'b0, 7'd0, 16'd0, 64'd0, cnt, status, 1'b1};
         want_q.push_back(r);
      end else begin
         foreach (step_out[k]) want_q.push_back(step_out[k]);
      end
      n_items++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (want_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [3:0] v);
      drain_and_settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = v;
   endtask

   // mostly well-formed word sequences; a fifth are raw byte noise
   task automatic send_query(input logic force_long);
      logic [7:0] q [$];
      int nwords;
      int wlen;
      int ending;
      int r;
      int i;
      logic last_on_end;
      logic zero_last;
      n_queries++;
      if ($urandom_range(4, 0) == 0) begin
         repeat ($urandom_range(16, 1)) q.push_back(8'($urandom_range(255, 0)));
         foreach (q[k]) begin
            send_item(q[k], k == 0, $urandom_range(9, 0) == 0, {$urandom, $urandom});
         end
      end else begin
         if ($urandom_range(3, 0) == 0) q.push_back(pick_delim());
         nwords = $urandom_range(5, 1);
         for (i = 0; i < nwords; i++) begin
            if (force_long && i == 0) wlen = 100;
            else if ($urandom_range(39, 0) == 0) wlen = $urandom_range(104, 90);
            else wlen = $urandom_range(9, 1);
            repeat (wlen) begin
               r = $urandom_range(63, 0);
               if (r < 10) q.push_back(8'("0" + r));
               else if (r < 36) q.push_back(8'("A" + r - 10));
               else if (r < 62) q.push_back(8'("a" + r - 36));
               else q.push_back((r == 62) ? 8'("_") : 8'("-"));
            end
            if (i != nwords - 1) begin
               q.push_back(pick_delim());
               if ($urandom_range(4, 0) == 0) q.push_back(pick_delim());
            end
         end
         ending = $urandom_range(2, 0);
         last_on_end = (ending != 1);
         zero_last = $urandom_range(1, 0);
         if (ending == 1) q.push_back(8'd0);
         if (ending == 2) q.push_back(pick_delim());
         foreach (q[k]) begin
            send_item(q[k], k == 0,
                      (k == q.size() - 1) ? (last_on_end | zero_last) : 1'b0,
                      {$urandom, $urandom});
         end
      end
      phase_items += q.size();
      // bytes past the end of a query are dropped by the block
      if ($urandom_range(3, 0) == 0) begin
         repeat ($urandom_range(3, 1)) begin
            send_item(8'($urandom_range(255, 0)), 1'b0, $urandom_range(1, 0),
                      {$urandom, $urandom});
         end
      end
   endtask

   function automatic string show(input tpe_result_type r);
      return {$sformatf("kind=%0d word=%h wlast=%0d len=%0d ",
                        r.kind, r.word, r.wlast, r.len),
              $sformatf("score=%h time=%h cnt=%0d st=%0d rl=%0d",
                        r.score, r.ptime, r.count, r.status, r.run_last)};
   endfunction

   task automatic report(input string what, input tpe_result_type exp_r,
                         input tpe_result_type got_r);
      if (mismatch_cnt < 10) begin
         $display("%0t ns %s", $time, what);
         $display("   expected %s", show(exp_r));
         $display("   actual   %s", show(got_r));
      end
      mismatch_cnt++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   always @(posedge clock) begin
      tpe_result_type seen;
      tpe_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_result_kind, rsp_token_word, rsp_word_last, rsp_token_length,
                  rsp_proposal_score, rsp_proposal_time, rsp_proposal_count,
                  rsp_done_status, rsp_run_last};
         if (seen.kind == KIND_DONE) n_done++;
         else n_words++;
         if (want_q.size() == 0) begin
            report("result transfer with nothing expected", '0, seen);
         end else begin
            exp_r = want_q.pop_front();
            if (seen !== exp_r) report("result mismatch", exp_r, seen);
         end
      end
   end

   initial begin
      int p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_LIMIT) begin
            write_limit(dir_rows[i].cnt);
         end else begin
            send_item(dir_rows[i].b, dir_rows[i].first, dir_rows[i].last, dir_rows[i].t,
                      dir_rows[i].typed, dir_rows[i].cnt, dir_rows[i].status);
         end
      end
      for (p = 0; p < PHASES; p++) begin
         write_limit(PHASE_LIMIT[p]);
         send_idle_pct = (p < 2) ? 32 : (p < 4) ? 84 : 0;
         recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 32 : 0;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_query(p == 0 && phase_items == 0);
      end
      drain_and_settle();
      $display("%0d query bytes sent (directed table plus %0d random queries)",
               n_items, n_queries);
      $display("%0d token words and %0d done summaries checked over six limit values",
               n_words, n_done);
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", want_q.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tpe_pkg.sv
rtl/tpe_queue.sv
rtl/tpe_front.sv
rtl/tpe_back.sv
rtl/token_proposal_extractor.sv
verif/tb.sv
